// ===== rtl/dcr_pkg.sv =====
// ----------------------------------------------------------------------------
// dcr_pkg
// Shared types and constants of the DMA channel register block.
// ----------------------------------------------------------------------------
package dcr_pkg;

    // Transaction kinds carried on the slave tuser field
    typedef enum logic [2:0] {
        OP_BUS_READ    = 3'd0,
        OP_BUS_WRITE   = 3'd1,
        OP_FRAME_DONE  = 3'd2,
        OP_TIMER_TICK  = 3'd3,
        OP_ENGINE_IDLE = 3'd4
    } t_op;

    localparam int WORD_IDX_W = 4;

    // Word indexes within a channel
    localparam logic [WORD_IDX_W-1:0] W_CTRL = 4'd0;
    localparam logic [WORD_IDX_W-1:0] W_STAT = 4'd1;
    localparam logic [WORD_IDX_W-1:0] W_TAIL = 4'd4;

    // Control word
    localparam int          CTRL_RUN_BIT     = 0;
    localparam int          CTRL_RESET_BIT   = 2;
    localparam logic [31:0] CTRL_TAILMODE    = 32'h0000_0002;
    localparam logic [31:0] CTRL_RESET_VALUE = 32'h0001_0000;

    // Status word (low half is stored, high half is built on read)
    localparam int          STAT_HALTED_BIT  = 0;
    localparam int          STAT_IDLE_BIT    = 1;
    localparam int          STAT_IOC_BIT     = 12;
    localparam int          STAT_DLY_BIT     = 13;
    localparam logic [15:0] STAT_RESET_VALUE = 16'h0001;
    localparam logic [15:0] STAT_IRQ_MASK    = 16'h7000;

    // Decoded register address
    typedef struct packed {
        logic                  chan;
        logic [WORD_IDX_W-1:0] word;
    } t_reg_sel;

endpackage

// ===== rtl/dcr_addr_decode.sv =====
// ----------------------------------------------------------------------------
// dcr_addr_decode
// Split a byte offset into channel and word index. The channel span is
// not a power of two, so the quotient comes from parallel compares.
// ----------------------------------------------------------------------------
module dcr_addr_decode
    import dcr_pkg::*;
#(
    parameter int REG_WORDS = 12,
    parameter int CHANNELS  = 2
) (
    input  logic [6:0] i_address,
    output t_reg_sel   o_sel
);

    localparam int CH_BYTES = 4 * REG_WORDS;
    localparam int QMAX     = 127 / CH_BYTES;

    logic [2:0] quo;
    logic [6:0] rem;

    always_comb begin
        quo = '0;
        rem = i_address;
        for (int k = 1; k <= QMAX; k++) begin
            if (i_address >= 7'(k * CH_BYTES)) begin
                quo = 3'(k);
                rem = i_address - 7'(k * CH_BYTES);
            end
        end
        // wrap channels beyond the last one
        o_sel.chan = (CHANNELS > 1) ? quo[0] : 1'b0;
        o_sel.word = rem[5:2];
    end

endmodule

// ===== rtl/dma_channel_regs_irq_coalesce_core.sv =====
// ----------------------------------------------------------------------------
// dma_channel_regs_irq_coalesce_core
// Per-channel DMA register file with completion and delay interrupt
// coalescing.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock cycle, back to back, while the
// master side takes results; each result passes the memory read stage and
// then the output register, a two-entry stage that absorbs a stalled master
// side so the slave side still takes one more transaction while one result
// waits. Results come from the read-modify-write of the per-channel control,
// status and coalescing registers and from the registered read of the word
// memory holding the remaining channel words (current and tail descriptor, storage).
// Transaction kinds: bus read, bus write, frame complete, delay-timer tick,
// engine idle; other kinds leave the state alone and return zero read data.
// Each result carries the two interrupt lines as they stand after that
// transaction, and a start request when the channel 0 tail word is written
// while the run bit of the channel 0 control word is set.
// ----------------------------------------------------------------------------
module dma_channel_regs_irq_coalesce_core
    import dcr_pkg::*;
#(
    parameter int REG_WORDS = 12,
    parameter int CHANNELS  = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // address[6:0], write_data[38:7], channel[39]
    input  logic [2:0]  i_s_tuser,   // operation[2:0]
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // read_data[31:0], irq_line_0[32],
                                     // irq_line_1[33], start_transmit[34], zero[39:35]
);

    localparam int MEM_DEPTH = CHANNELS * REG_WORDS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // ------------------------------------------------------------------
    // Unpack the slave transaction
    // ------------------------------------------------------------------
    logic [2:0]  op;
    logic [6:0]  addr;
    logic [31:0] wdata;
    logic        evch;
    logic        accept;
    t_reg_sel    sel;
    logic        ch;

    assign op     = i_s_tuser;
    assign addr   = i_s_tdata[6:0];
    assign wdata  = i_s_tdata[38:7];
    assign evch   = (CHANNELS > 1) ? i_s_tdata[39] : 1'b0;
    assign accept = i_s_tvalid && o_s_tready;

    dcr_addr_decode #(
        .REG_WORDS (REG_WORDS),
        .CHANNELS  (CHANNELS)
    ) u_addr_decode (
        .i_address (addr),
        .o_sel     (sel)
    );

    // Bus accesses address a channel by offset, events by their own field
    assign ch = (op == OP_BUS_READ || op == OP_BUS_WRITE) ? sel.chan : evch;

    // ------------------------------------------------------------------
    // Per-channel control, status and coalescing state
    // ------------------------------------------------------------------
    logic [31:0] r_ctrl [CHANNELS];
    logic [15:0] r_stat [CHANNELS];
    logic [31:0] r_cnt  [CHANNELS];
    logic [7:0]  r_dly  [CHANNELS];
    logic        r_run  [CHANNELS];
    logic [31:0] n_ctrl [CHANNELS];
    logic [15:0] n_stat [CHANNELS];
    logic [31:0] n_cnt  [CHANNELS];
    logic [7:0]  n_dly  [CHANNELS];
    logic        n_run  [CHANNELS];

    logic [31:0] cur_ctrl, nx_ctrl;
    logic [15:0] cur_stat, nx_stat;
    logic [31:0] cur_cnt, nx_cnt, cnt_dec;
    logic [7:0]  cur_dly, nx_dly, dly_dec;
    logic        cur_run, nx_run;
    logic [31:0] rd_val;
    logic        use_mem;
    logic        mem_we;
    logic        start;

    assign cur_ctrl = r_ctrl[ch];
    assign cur_stat = r_stat[ch];
    assign cur_cnt  = r_cnt[ch];
    assign cur_dly  = r_dly[ch];
    assign cur_run  = r_run[ch];
    assign cnt_dec  = cur_cnt - 32'd1;
    assign dly_dec  = cur_dly - 8'd1;

    // Read-modify-write of the addressed channel
    always_comb begin
        nx_ctrl = cur_ctrl;
        nx_stat = cur_stat;
        nx_cnt  = cur_cnt;
        nx_dly  = cur_dly;
        nx_run  = cur_run;
        rd_val  = '0;
        use_mem = 1'b0;
        mem_we  = 1'b0;
        start   = 1'b0;
        case (op)
            OP_BUS_READ: begin
                if (sel.word == W_CTRL) begin
                    // stored reset bit is never set, so nothing to clear
                    rd_val = cur_ctrl;
                end else if (sel.word == W_STAT) begin
                    // high half shows the live timer and countdown
                    rd_val = {cur_dly, cur_cnt[7:0], cur_stat};
                end else begin
                    use_mem = 1'b1;
                end
            end
            OP_BUS_WRITE: begin
                if (sel.word == W_CTRL) begin
                    nx_ctrl = wdata | CTRL_TAILMODE;
                    if (wdata[CTRL_RESET_BIT]) begin
                        nx_ctrl = CTRL_RESET_VALUE;
                        nx_stat = STAT_RESET_VALUE;
                    end
                    if (wdata[CTRL_RUN_BIT]) begin
                        nx_stat[STAT_HALTED_BIT] = 1'b0;
                        nx_stat[STAT_IDLE_BIT]   = 1'b0;
                    end
                    nx_cnt = {24'd0, nx_ctrl[23:16]};
                end else if (sel.word == W_STAT) begin
                    // interrupt bits are write-one-to-clear
                    nx_stat = (wdata[15:0] & ~STAT_IRQ_MASK)
                            | (cur_stat & STAT_IRQ_MASK & ~wdata[15:0]);
                end else begin
                    mem_we = 1'b1;
                    if (sel.word == W_TAIL) begin
                        nx_stat[STAT_IDLE_BIT] = 1'b0;
                        start = !sel.chan && cur_ctrl[CTRL_RUN_BIT];
                    end
                end
            end
            OP_FRAME_DONE: begin
                // (re)arm the one-shot delay timer
                if (cur_ctrl[31:24] != 8'd0) begin
                    nx_dly = cur_ctrl[31:24];
                    nx_run = 1'b1;
                end
                nx_cnt = cnt_dec;
                if (cnt_dec == 32'd0) begin
                    nx_stat[STAT_IOC_BIT] = 1'b1;
                    nx_cnt = {24'd0, cur_ctrl[23:16]};
                end
            end
            OP_TIMER_TICK: begin
                if (cur_run) begin
                    nx_dly = dly_dec;
                    if (dly_dec == 8'd0) begin
                        nx_run = 1'b0;
                        nx_cnt = {24'd0, cur_ctrl[23:16]};
                        nx_stat[STAT_DLY_BIT] = 1'b1;
                    end
                end
            end
            OP_ENGINE_IDLE: begin
                nx_stat[STAT_IDLE_BIT] = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_ctrl = r_ctrl;
        n_stat = r_stat;
        n_cnt  = r_cnt;
        n_dly  = r_dly;
        n_run  = r_run;
        if (accept) begin
            n_ctrl[ch] = nx_ctrl;
            n_stat[ch] = nx_stat;
            n_cnt[ch]  = nx_cnt;
            n_dly[ch]  = nx_dly;
            n_run[ch]  = nx_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_ctrl[c] <= CTRL_RESET_VALUE;
                r_stat[c] <= STAT_RESET_VALUE;
                r_cnt[c]  <= '0;
                r_dly[c]  <= '0;
                r_run[c]  <= 1'b0;
            end
        end else begin
            r_ctrl <= n_ctrl;
            r_stat <= n_stat;
            r_cnt  <= n_cnt;
            r_dly  <= n_dly;
            r_run  <= n_run;
        end
    end

    // Interrupt lines as they stand after this transaction
    logic irq0, irq1;

    assign irq0 = |(n_stat[0][14:12] & n_ctrl[0][14:12]);
    assign irq1 = (CHANNELS > 1) ?
                  |(n_stat[CHANNELS-1][14:12] & n_ctrl[CHANNELS-1][14:12]) : 1'b0;

    // ------------------------------------------------------------------
    // Word memory for descriptor and storage words
    // ------------------------------------------------------------------
    logic [31:0]       mem [MEM_DEPTH];
    logic              r_mem_vld [MEM_DEPTH];
    logic              n_mem_vld [MEM_DEPTH];
    logic [MEM_AW-1:0] mem_addr;
    logic [31:0]       r_mem_q;

    assign mem_addr = MEM_AW'(sel.chan) * MEM_AW'(REG_WORDS) + MEM_AW'(sel.word);

    always_ff @(posedge i_clk) begin
        if (accept && mem_we) begin
            mem[mem_addr] <= wdata;
        end
        if (accept && use_mem) begin
            r_mem_q <= mem[mem_addr];
        end
    end

    // Words never written read as zero
    always_comb begin
        n_mem_vld = r_mem_vld;
        if (accept && mem_we) begin
            n_mem_vld[mem_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < MEM_DEPTH; e++) begin
                r_mem_vld[e] <= 1'b0;
            end
        end else begin
            r_mem_vld <= n_mem_vld;
        end
    end

    // ------------------------------------------------------------------
    // Result pipeline: memory read stage, then output register
    // ------------------------------------------------------------------
    logic        r_s1_valid, n_s1_valid;
    logic [31:0] r_s1_rd;
    logic        r_s1_use_mem;
    logic        r_s1_mem_vld;
    logic        r_s1_irq0, r_s1_irq1, r_s1_start;
    logic        r_out_valid, n_out_valid;
    logic [39:0] r_out_data;
    logic        s1_adv;
    logic [31:0] s1_rdata;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign s1_rdata   = r_s1_use_mem ? (r_s1_mem_vld ? r_mem_q : 32'd0) : r_s1_rd;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload: capture on accept, hold while stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rd      <= rd_val;
            r_s1_use_mem <= use_mem;
            r_s1_mem_vld <= r_mem_vld[mem_addr];
            r_s1_irq0    <= irq0;
            r_s1_irq1    <= irq1;
            r_s1_start   <= start;
        end
        if (s1_adv) begin
            r_out_data <= {5'd0, r_s1_start, r_s1_irq1, r_s1_irq0, s1_rdata};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
